@@ rtl/clle_pkg.sv @@
`default_nettype none

package clle_pkg;

   // Defaults for the top-level parameters.
   localparam int CLLE_CAPACITY   = 256;
   localparam int CLLE_DATA_WIDTH = 8;

   // Fixed field widths of the channels.
   localparam int MODE_W   = 2;
   localparam int VALUE_W  = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 9;
   localparam int CVAL_W   = 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_ERASE  = 2'd1,
      MODE_LEFT   = 2'd2,
      MODE_RIGHT  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE     = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_EMPTY    = 2'd2,
      STAT_BOUNDARY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LINK,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
      logic relink;
      logic publish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_relink;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

@@ rtl/clle_req_if.sv @@
`default_nettype none

interface clle_req_if import clle_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output mode, output value, input ready);
   modport sink (input valid, input mode, input value, output ready);
endinterface

`default_nettype wire

@@ rtl/clle_rsp_if.sv @@
`default_nettype none

interface clle_rsp_if import clle_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  element_count;
   logic [CVAL_W-1:0]   cursor_value;
   logic                cursor_at_front;

   modport source (output valid, output status, output element_count,
                   output cursor_value, output cursor_at_front, input ready);
   modport sink (input valid, input status, input element_count,
                 input cursor_value, input cursor_at_front, output ready);
endinterface

`default_nettype wire

@@ rtl/clle_ram.sv @@
`default_nettype none

module clle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/clle_ctrl.sv @@
`default_nettype none

module clle_ctrl import clle_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = stat.need_relink ? ST_LINK : ST_DONE;
         end
         ST_LINK: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
         end
         ST_LINK: begin
            cmd.relink = 1'b1;
         end
         ST_DONE: begin
            cmd.publish = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/clle_datapath.sv @@
`default_nettype none

module clle_datapath import clle_pkg::*; #(
   parameter int CAPACITY   = CLLE_CAPACITY,
   parameter int DATA_WIDTH = CLLE_DATA_WIDTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output stat_type                 stat,
   input  wire logic [MODE_W-1:0]   req_mode,
   input  wire logic [VALUE_W-1:0]  req_value,
   input  wire logic                rsp_ready,
   output logic                     rsp_valid,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [COUNT_W-1:0]       rsp_element_count,
   output logic [CVAL_W-1:0]        rsp_cursor_value,
   output logic                     rsp_cursor_at_front
);

   localparam int IDX_W  = $clog2(CAPACITY + 2);
   localparam int POOL_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam logic [IDX_W-1:0] FRONT_IDX = IDX_W'(CAPACITY);
   localparam logic [IDX_W-1:0] BACK_IDX  = IDX_W'(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT   = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

   // Control state.
   logic [IDX_W-1:0] cursor_ff, cursor_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] size_ff, size_in;
   logic [CNT_W-1:0] free_top_ff, free_top_in;
   logic [CNT_W-1:0] fresh_ff, fresh_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Per-item working registers.
   mode_type             mode_ff;
   logic [VALUE_W-1:0]   value_ff;
   status_type           status_ff, status_in;
   logic [IDX_W-1:0]     node_ff, node_in;
   logic [IDX_W-1:0]     after_ff, after_in;
   logic [IDX_W-1:0]     origin_ff, origin_in;

   // Result register.
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic [CVAL_W-1:0]    rsp_cval_ff;
   logic                 rsp_front_ff;

   // Memory ports.
   logic [IDX_W-1:0]      next_rd, prev_rd;
   logic [POOL_W-1:0]     fs_rd;
   logic [DATA_WIDTH-1:0] elem_rd;
   logic                  next_we, prev_we, fs_we, elem_we, elem_re;
   logic [POOL_W-1:0]     next_wa, prev_wa, fs_wa, elem_wa, elem_ra, fs_ra;
   logic [IDX_W-1:0]      next_wd, prev_wd;
   logic [DATA_WIDTH-1:0] elem_wd;

   logic                  cur_front, full, from_stack;
   logic [IDX_W-1:0]      succ, pred, new_node;
   logic [CNT_W-1:0]      top_dec;
   logic [VALUE_W+DATA_WIDTH-1:0] value_wide;
   logic [DATA_WIDTH+CVAL_W-1:0]  elem_wide;
   logic [CNT_W+COUNT_W-1:0]      count_wide;

   clle_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_next_ram (
      .clock(clock), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_en(cmd.capture), .rd_addr(cursor_ff[POOL_W-1:0]), .rd_data(next_rd)
   );

   clle_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_prev_ram (
      .clock(clock), .wr_en(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd),
      .rd_en(cmd.capture), .rd_addr(cursor_ff[POOL_W-1:0]), .rd_data(prev_rd)
   );

   clle_ram #(.WIDTH(POOL_W), .DEPTH(CAPACITY)) u_free_ram (
      .clock(clock), .wr_en(fs_we), .wr_addr(fs_wa), .wr_data(cursor_ff[POOL_W-1:0]),
      .rd_en(cmd.capture), .rd_addr(fs_ra), .rd_data(fs_rd)
   );

   clle_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_elem_ram (
      .clock(clock), .wr_en(elem_we), .wr_addr(elem_wa), .wr_data(elem_wd),
      .rd_en(elem_re), .rd_addr(elem_ra), .rd_data(elem_rd)
   );

   assign top_dec    = free_top_ff - ONE_CNT;
   assign fs_ra      = top_dec[POOL_W-1:0];
   assign value_wide = {{DATA_WIDTH{1'b0}}, value_ff};
   assign elem_wide  = {{CVAL_W{1'b0}}, elem_rd};
   assign count_wide = {{COUNT_W{1'b0}}, size_ff};

   assign cur_front  = (cursor_ff == FRONT_IDX);
   assign succ       = cur_front ? head_ff : next_rd;
   assign pred       = prev_rd;
   assign full       = (size_ff >= CAP_CNT);
   assign from_stack = (free_top_ff != '0);
   assign new_node   = from_stack ? IDX_W'(fs_rd) : IDX_W'(fresh_ff);

   assign stat.need_relink = (mode_ff == MODE_INSERT) && !full;
   assign stat.out_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cursor_in   = cursor_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      size_in     = size_ff;
      free_top_in = free_top_ff;
      fresh_in    = fresh_ff;
      status_in   = status_ff;
      node_in     = node_ff;
      after_in    = after_ff;
      origin_in   = origin_ff;
      next_we     = 1'b0;
      next_wa     = '0;
      next_wd     = '0;
      prev_we     = 1'b0;
      prev_wa     = '0;
      prev_wd     = '0;
      fs_we       = 1'b0;
      fs_wa       = free_top_ff[POOL_W-1:0];
      elem_we     = 1'b0;
      elem_wa     = '0;
      elem_wd     = value_wide[DATA_WIDTH-1:0];

      if (cmd.execute) begin
         status_in = STAT_DONE;
         unique case (mode_ff)
            MODE_INSERT: begin
               if (full) begin
                  status_in = STAT_FULL;
               end else begin
                  // Fill in the new node; its neighbors are relinked next cycle.
                  node_in   = new_node;
                  after_in  = succ;
                  origin_in = cursor_ff;
                  elem_we   = 1'b1;
                  elem_wa   = new_node[POOL_W-1:0];
                  next_we   = 1'b1;
                  next_wa   = new_node[POOL_W-1:0];
                  next_wd   = succ;
                  prev_we   = 1'b1;
                  prev_wa   = new_node[POOL_W-1:0];
                  prev_wd   = cursor_ff;
                  cursor_in = new_node;
                  size_in   = size_ff + ONE_CNT;
                  if (from_stack) begin
                     free_top_in = top_dec;
                  end else begin
                     fresh_in = fresh_ff + ONE_CNT;
                  end
               end
            end
            MODE_ERASE: begin
               if (cur_front) begin
                  status_in = STAT_EMPTY;
               end else begin
                  // Unhook the node and push it on the free stack.
                  if (pred == FRONT_IDX) begin
                     head_in = succ;
                  end else begin
                     next_we = 1'b1;
                     next_wa = pred[POOL_W-1:0];
                     next_wd = succ;
                  end
                  if (succ == BACK_IDX) begin
                     tail_in = pred;
                  end else begin
                     prev_we = 1'b1;
                     prev_wa = succ[POOL_W-1:0];
                     prev_wd = pred;
                  end
                  fs_we       = 1'b1;
                  free_top_in = free_top_ff + ONE_CNT;
                  cursor_in   = pred;
                  size_in     = size_ff - ONE_CNT;
               end
            end
            MODE_LEFT: begin
               if (cur_front) begin
                  status_in = STAT_BOUNDARY;
               end else begin
                  cursor_in = pred;
               end
            end
            MODE_RIGHT: begin
               if (succ == BACK_IDX) begin
                  status_in = STAT_BOUNDARY;
               end else begin
                  cursor_in = succ;
               end
            end
            default: begin
               status_in = STAT_DONE;
            end
         endcase
      end

      if (cmd.relink) begin
         if (origin_ff == FRONT_IDX) begin
            head_in = node_ff;
         end else begin
            next_we = 1'b1;
            next_wa = origin_ff[POOL_W-1:0];
            next_wd = node_ff;
         end
         if (after_ff == BACK_IDX) begin
            tail_in = node_ff;
         end else begin
            prev_we = 1'b1;
            prev_wa = after_ff[POOL_W-1:0];
            prev_wd = node_ff;
         end
      end
   end

   // The element under the new cursor is read in the last working cycle.
   assign elem_re = cmd.execute || cmd.relink;
   assign elem_ra = cursor_in[POOL_W-1:0];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= FRONT_IDX;
         head_ff      <= BACK_IDX;
         tail_ff      <= FRONT_IDX;
         size_ff      <= '0;
         free_top_ff  <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cursor_ff    <= cursor_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         size_ff      <= size_in;
         free_top_ff  <= free_top_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= mode_type'(req_mode);
         value_ff <= req_value;
      end
      status_ff <= status_in;
      node_ff   <= node_in;
      after_ff  <= after_in;
      origin_ff <= origin_in;
      if (cmd.publish) begin
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= count_wide[COUNT_W-1:0];
         rsp_cval_ff   <= cur_front ? '0 : elem_wide[CVAL_W-1:0];
         rsp_front_ff  <= cur_front;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_element_count   = rsp_count_ff;
   assign rsp_cursor_value    = rsp_cval_ff;
   assign rsp_cursor_at_front = rsp_front_ff;

endmodule

`default_nettype wire

@@ rtl/cursor_linked_list_editor_unit.sv @@
`default_nettype none

// Channel   Direction  Handshake        Payload
// req_if    in         valid / ready    mode, value
// rsp_if    out        valid / ready    status, element_count, cursor_value, cursor_at_front
//
// A move, an erase or an insert into a full list passes the execute and done states;
// an insert that lands also passes the relink state, and a new transfer waits for idle.
// The link memories have a registered read and write one entry a cycle: an insert
// writes the new node's own links first and its neighbors' links in the next cycle.
// The result sits in an output register, so the next transfer is taken while
// it waits; a new result waits in the last state until that register is free.
// Reset is synchronous; the list is empty and usable on the cycle after it,
// with no clearing pass, since the sentinel links are held in flip-flops.
module cursor_linked_list_editor_unit import clle_pkg::*; #(
   parameter int CAPACITY   = CLLE_CAPACITY,
   parameter int DATA_WIDTH = CLLE_DATA_WIDTH
) (
   input wire logic  clock,
   input wire logic  reset,
   clle_req_if.sink  req_if,
   clle_rsp_if.source rsp_if
);

   // The controller sequences capture, execution, relinking and publication;
   // the datapath holds the list state, the memories and the result register.
   cmd_type  cmd;
   stat_type stat;

   clle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   clle_datapath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_mode            (req_if.mode),
      .req_value           (req_if.value),
      .rsp_ready           (rsp_if.ready),
      .rsp_valid           (rsp_if.valid),
      .rsp_status          (rsp_if.status),
      .rsp_element_count   (rsp_if.element_count),
      .rsp_cursor_value    (rsp_if.cursor_value),
      .rsp_cursor_at_front (rsp_if.cursor_at_front)
   );

endmodule

`default_nettype wire

@@ test/cursor_linked_list_editor_unit_tb.sv @@
module cursor_linked_list_editor_unit_tb import clle_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   // Regression bench for the cursor linked list editor. Every accepted request
   // is run through a behavioral copy of the list kept here: node links, element
   // data, free stack, cursor and size. The result is queued and compared, field
   // by field, with what the block returns. A short table of hand-picked
   // operations opens the run. Random phases follow: a mixed warm-up, a fill to
   // capacity, a drain that recycles freed nodes, and a last stretch without
   // any idling.

   localparam int CAP              = CLLE_CAPACITY;
   localparam int DIRECTED_ROWS    = 25;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 16;

   // The pool holds CAP nodes, and the two sentinels sit just above it.
   localparam logic [COUNT_W-1:0] FRONT_NODE = COUNT_W'(CAP);
   localparam logic [COUNT_W-1:0] BACK_NODE  = COUNT_W'(CAP + 1);

   // One result transfer, in the layout of the response channel.
   typedef struct packed {
      status_type          status;
      logic [COUNT_W-1:0]  count;
      logic [CVAL_W-1:0]   cval;
      logic                at_front;
   } op_result_type;

   // One row of the directed table. When typed is set, want is the result to
   // expect. Otherwise the list copy below supplies the expectation.
   typedef struct packed {
      mode_type            mode;
      logic [VALUE_W-1:0]  value;
      logic                typed;
      op_result_type       want;
   } op_row_type;

   localparam op_result_type UNTYPED = '{STAT_DONE, 9'd0, 8'h00, 1'b0};

   logic clock = 1'b0;
   logic reset = 1'b1;

   clle_req_if req_bus ();
   clle_rsp_if rsp_bus ();

   cursor_linked_list_editor_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // This is the bench's own copy of the list. It is updated once for each
   // accepted request, in order of acceptance.
   logic [COUNT_W-1:0] link_next [CAP+2];
   logic [COUNT_W-1:0] link_prev [CAP+2];
   logic [VALUE_W-1:0] node_data [CAP];
   logic [7:0]         free_nodes [CAP];
   logic [COUNT_W-1:0] free_depth;
   logic [COUNT_W-1:0] fresh_next;
   logic [COUNT_W-1:0] cursor;
   logic [COUNT_W-1:0] list_size;

   op_result_type expected_results [$];

   int  mismatch_count = 0;
   int  ops_sent       = 0;
   int  results_seen   = 0;
   int  peak_size      = 0;
   int  status_tally [4] = '{0, 0, 0, 0};
   bit  pacing_on         = 1'b1;
   bit  long_hold_pending = 1'b0;

   // The directed opening. It starts with the boundary cases of an empty list.
   // Next comes a two-element walk past both ends, and then an insert in the
   // middle of the list. An erase follows, and the next insert reuses the freed
   // node. The table ends with erases at the head and tail, a full drain, and
   // an insert into the emptied list.
   op_row_type directed_ops [DIRECTED_ROWS] = '{
      '{MODE_LEFT,   8'h00, 1'b1, '{STAT_BOUNDARY, 9'd0, 8'h00, 1'b1}},
      '{MODE_RIGHT,  8'hFF, 1'b1, '{STAT_BOUNDARY, 9'd0, 8'h00, 1'b1}},
      '{MODE_ERASE,  8'h00, 1'b1, '{STAT_EMPTY,    9'd0, 8'h00, 1'b1}},
      '{MODE_INSERT, 8'hFF, 1'b1, '{STAT_DONE,     9'd1, 8'hFF, 1'b0}},
      '{MODE_INSERT, 8'h00, 1'b1, '{STAT_DONE,     9'd2, 8'h00, 1'b0}},
      '{MODE_RIGHT,  8'h00, 1'b1, '{STAT_BOUNDARY, 9'd2, 8'h00, 1'b0}},
      '{MODE_LEFT,   8'h00, 1'b1, '{STAT_DONE,     9'd2, 8'hFF, 1'b0}},
      '{MODE_LEFT,   8'h00, 1'b1, '{STAT_DONE,     9'd2, 8'h00, 1'b1}},
      '{MODE_LEFT,   8'hFF, 1'b1, '{STAT_BOUNDARY, 9'd2, 8'h00, 1'b1}},
      '{MODE_ERASE,  8'hFF, 1'b1, '{STAT_EMPTY,    9'd2, 8'h00, 1'b1}},
      '{MODE_RIGHT,  8'h00, 1'b1, '{STAT_DONE,     9'd2, 8'hFF, 1'b0}},
      '{MODE_INSERT, 8'hA5, 1'b0, UNTYPED},
      '{MODE_ERASE,  8'h00, 1'b0, UNTYPED},
      '{MODE_INSERT, 8'h5A, 1'b0, UNTYPED},
      '{MODE_LEFT,   8'h00, 1'b0, UNTYPED},
      '{MODE_ERASE,  8'h00, 1'b0, UNTYPED},
      '{MODE_INSERT, 8'h3C, 1'b0, UNTYPED},
      '{MODE_RIGHT,  8'h00, 1'b0, UNTYPED},
      '{MODE_RIGHT,  8'h00, 1'b0, UNTYPED},
      '{MODE_ERASE,  8'h00, 1'b0, UNTYPED},
      '{MODE_ERASE,  8'h00, 1'b0, UNTYPED},
      '{MODE_ERASE,  8'h00, 1'b0, UNTYPED},
      '{MODE_ERASE,  8'h00, 1'b1, '{STAT_EMPTY,    9'd0, 8'h00, 1'b1}},
      '{MODE_INSERT, 8'h81, 1'b1, '{STAT_DONE,     9'd1, 8'h81, 1'b0}},
      '{MODE_LEFT,   8'h7E, 1'b1, '{STAT_DONE,     9'd1, 8'h00, 1'b1}}
   };

   // The empty list: the front sentinel links straight to the back sentinel,
   // and the cursor rests on the front sentinel.
   task automatic clear_list_copy();
      foreach (link_next[i]) begin
         link_next[i] = '0;
         link_prev[i] = '0;
      end
      foreach (node_data[i]) begin
         node_data[i]  = '0;
         free_nodes[i] = '0;
      end
      link_next[FRONT_NODE] = BACK_NODE;
      link_prev[BACK_NODE]  = FRONT_NODE;
      free_depth = '0;
      fresh_next = '0;
      cursor     = FRONT_NODE;
      list_size  = '0;
   endtask

   // This applies one edit to the list copy and returns the result it must
   // produce. Freed nodes are handed out again before any node that was
   // never used.
   function automatic op_result_type apply_list_op(mode_type op, logic [VALUE_W-1:0] data);
      op_result_type      res;
      logic [COUNT_W-1:0] slot;
      logic [COUNT_W-1:0] after;
      logic [COUNT_W-1:0] pred;
      logic [COUNT_W-1:0] succ;
      res.status = STAT_DONE;
      case (op)
         MODE_INSERT: begin
            if (list_size >= CAP) begin
               res.status = STAT_FULL;
            end else begin
               if (free_depth > 0) begin
                  free_depth--;
                  slot = COUNT_W'(free_nodes[free_depth]);
               end else begin
                  slot = fresh_next;
                  fresh_next++;
               end
               after = link_next[cursor];
               node_data[slot] = data;
               link_next[slot] = after;
               link_prev[slot] = cursor;
               link_prev[after] = slot;
               link_next[cursor] = slot;
               cursor = slot;
               list_size++;
            end
         end
         MODE_ERASE: begin
            if (cursor >= CAP) begin
               res.status = STAT_EMPTY;
            end else begin
               pred = link_prev[cursor];
               succ = link_next[cursor];
               link_next[pred] = succ;
               link_prev[succ] = pred;
               free_nodes[free_depth] = cursor[7:0];
               free_depth++;
               cursor = pred;
               list_size--;
            end
         end
         MODE_LEFT: begin
            if (cursor == FRONT_NODE) res.status = STAT_BOUNDARY;
            else cursor = link_prev[cursor];
         end
         default: begin
            if (link_next[cursor] == BACK_NODE) res.status = STAT_BOUNDARY;
            else cursor = link_next[cursor];
         end
      endcase
      res.count    = list_size;
      res.cval     = (cursor < CAP) ? node_data[cursor] : '0;
      res.at_front = (cursor == FRONT_NODE);
      return res;
   endfunction

   task automatic note_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // This offers one request, waits for its transfer, and records what it
   // should return. The task is entered and left at a falling edge. A random
   // idle gap may come first, while idling is on.
   task automatic send_op(input mode_type op, input logic [VALUE_W-1:0] data,
                          input logic use_typed, input op_result_type typed);
      op_result_type predicted;
      if (pacing_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode  <= op;
      req_bus.value <= data;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = apply_list_op(op, data);
      expected_results.push_back(use_typed ? typed : predicted);
      status_tally[int'(predicted.status)]++;
      if (int'(list_size) > peak_size) peak_size = int'(list_size);
      ops_sent++;
      @(negedge clock);
   endtask

   function automatic mode_type pick_mode(int w_ins, int w_era, int w_left, int w_right);
      int roll;
      roll = $urandom_range(0, w_ins + w_era + w_left + w_right - 1);
      if (roll < w_ins) return MODE_INSERT;
      if (roll < w_ins + w_era) return MODE_ERASE;
      if (roll < w_ins + w_era + w_left) return MODE_LEFT;
      return MODE_RIGHT;
   endfunction

   task automatic run_random_ops(input int count, input int w_ins, input int w_era,
                                 input int w_left, input int w_right);
      repeat (count)
         send_op(pick_mode(w_ins, w_era, w_left, w_right),
                 VALUE_W'($urandom_range(0, 255)), 1'b0, UNTYPED);
   endtask

   // Result checking. Each result transfer is compared with the oldest
   // expectation still waiting.
   always @(posedge clock) begin
      op_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            note_mismatch("result arrived with no request waiting for it");
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.status != want.status)
               note_mismatch($sformatf("status %0d, wanted %0d",
                                       rsp_bus.status, want.status));
            if (rsp_bus.element_count != want.count)
               note_mismatch($sformatf("element_count %0d, wanted %0d",
                                       rsp_bus.element_count, want.count));
            if (rsp_bus.cursor_value != want.cval)
               note_mismatch($sformatf("cursor_value %0h, wanted %0h",
                                       rsp_bus.cursor_value, want.cval));
            if (rsp_bus.cursor_at_front != want.at_front)
               note_mismatch($sformatf("cursor_at_front %0b, wanted %0b",
                                       rsp_bus.cursor_at_front, want.at_front));
         end
      end
   end

   // Response side pacing. Random stalls are used while idling is on. One long
   // hold-off, on request, backs the block up so that it has to refuse new
   // requests.
   initial begin
      int hold_cycles;
      rsp_bus.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_bus.ready <= 1'b0;
            for (hold_cycles = 1; hold_cycles < LONG_HOLD_CYCLES; hold_cycles++)
               @(negedge clock);
         end else if (pacing_on && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(0, 13)) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // A correct run needs well under a tenth of this time.
   initial begin
      #400000;
      $display("cursor_linked_list_editor_unit regression: fail");
      $finish;
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.mode  = MODE_INSERT;
      req_bus.value = '0;
      clear_list_copy();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_ops[i])
         send_op(directed_ops[i].mode, directed_ops[i].value,
                 directed_ops[i].typed, directed_ops[i].want);

      // This is a mixed warm-up that wanders around a short list.
      run_random_ops(30, 3, 2, 2, 2);

      // Fill to capacity while the response side holds off for a long time
      // at the start. Then hammer the full list with inserts and cursor moves.
      long_hold_pending = 1'b1;
      while (list_size < CAP)
         send_op(pick_mode(20, 1, 1, 1), VALUE_W'($urandom_range(0, 255)), 1'b0, UNTYPED);
      run_random_ops(8, 4, 0, 1, 1);

      // The sender pauses until every outstanding result has come back.
      req_bus.valid <= 1'b0;
      wait (expected_results.size() == 0);
      @(negedge clock);

      // This phase is mostly erases, so the free stack fills up.
      run_random_ops(60, 1, 6, 2, 3);

      // The last stretch has no idling on either side. Its inserts mostly
      // reuse freed nodes.
      pacing_on = 1'b0;
      run_random_ops(50, 4, 2, 2, 2);
      req_bus.valid <= 1'b0;

      wait (expected_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d list edits, %0d results compared; list peaked at %0d of %0d nodes.",
               ops_sent, results_seen, peak_size, CAP);
      $display("Statuses: %0d done, %0d full, %0d nothing to erase, %0d at boundary.",
               status_tally[STAT_DONE], status_tally[STAT_FULL],
               status_tally[STAT_EMPTY], status_tally[STAT_BOUNDARY]);
      if (mismatch_count == 0) begin
         $display("cursor_linked_list_editor_unit regression: pass");
      end else begin
         $display("cursor_linked_list_editor_unit regression: fail");
      end
      $finish;
   end

endmodule
